### rtl/core/binary_min_heap_queue_top_macros.svh
// Assertion macros shared by the heap queue RTL.
// Each macro expects clk, and BMHQ_ASSERT also rst_n, to be visible where it is used.
`ifndef BINARY_MIN_HEAP_QUEUE_TOP_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_TOP_MACROS_SVH

// Checked only outside reset.
`define BMHQ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define BMHQ_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/bmhq_pkg.sv
package bmhq_pkg;

    localparam int KEY_W        = 31;
    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 11;
    localparam int CAPACITY_DEF = 1024;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } entry_t;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [DATA_W-1:0]   data;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occupancy;
    } res_t;

endpackage

### rtl/core/bmhq_if.sv
interface bmhq_req_if;
    import bmhq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [KEY_W-1:0]         in_key;
    logic signed [DATA_W-1:0] in_data;

    modport source (output valid, output req_type, output in_key, output in_data,
                    input ready);
    modport sink   (input valid, input req_type, input in_key, input in_data,
                    output ready);
endinterface

interface bmhq_rsp_if;
    import bmhq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KEY_W-1:0]         out_key;
    logic signed [DATA_W-1:0] out_data;
    logic [STATUS_W-1:0]      status;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, output out_key, output out_data, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input out_key, input out_data, input status,
                    input occupancy, output ready);
endinterface

### rtl/core/bmhq_ram.sv
module bmhq_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/bmhq_ctrl.sv
`include "binary_min_heap_queue_top_macros.svh"

module bmhq_ctrl #(
    parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    bmhq_req_if.sink                      req,
    output bmhq_pkg::res_t                res,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic                          mem_re,
    output logic [$clog2(CAPACITY)-1:0]   mem_raddr,
    input  bmhq_pkg::entry_t              mem_rdata,
    output logic                          mem_we,
    output logic [$clog2(CAPACITY)-1:0]   mem_waddr,
    output bmhq_pkg::entry_t              mem_wdata
);
    import bmhq_pkg::*;

    localparam int IDX_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP_CMP  = 3'd1;
    localparam logic [2:0] S_DN_ROOT = 3'd2;
    localparam logic [2:0] S_DN_LAST = 3'd3;
    localparam logic [2:0] S_DN_L    = 3'd4;
    localparam logic [2:0] S_DN_R    = 3'd5;
    localparam logic [2:0] S_WFIN    = 3'd6;
    localparam logic [2:0] S_EMIT    = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [IDX_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    entry_t              mov_reg, mov_next;
    entry_t              left_reg, left_next;
    logic [KEY_W-1:0]    res_key_reg, res_key_next;
    logic [DATA_W-1:0]   res_data_reg, res_data_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;

    logic [IDX_W-1:0]    ins_idx;
    logic [IDX_W-1:0]    parent_idx;
    logic [IDX_W:0]      lc_wide;
    logic [IDX_W-1:0]    lc_idx;
    logic [IDX_W-1:0]    rc_idx;
    logic                pick_right;
    entry_t              cand;
    logic [IDX_W-1:0]    cand_idx;
    logic [IDX_W:0]      gc_wide;
    logic                gc_ok;

    // Heap positions run from 1; the memory is addressed from 0.
    function automatic logic [ADDR_W-1:0] idx_to_addr(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] d;
        d = idx - IDX_W'(1);
        return d[ADDR_W-1:0];
    endfunction

    assign req.ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT);

    assign res.key       = res_key_reg;
    assign res.data      = res_data_reg;
    assign res.status    = res_status_reg;
    assign res.occupancy = OCC_W'(count_reg);

    assign ins_idx    = count_reg + IDX_W'(1);
    assign parent_idx = idx_reg >> 1;
    assign lc_wide    = {idx_reg, 1'b0};
    assign lc_idx     = lc_wide[IDX_W-1:0];
    assign rc_idx     = lc_idx + IDX_W'(1);
    assign pick_right = (state_reg == S_DN_R) && (mem_rdata.key < left_reg.key);
    assign cand       = (state_reg == S_DN_R && !pick_right) ? left_reg : mem_rdata;
    assign cand_idx   = pick_right ? rc_idx : lc_idx;
    assign gc_wide    = {cand_idx, 1'b0};
    assign gc_ok      = (gc_wide <= {1'b0, count_reg});

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        mov_next        = mov_reg;
        left_next       = left_reg;
        res_key_next    = res_key_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        mem_we          = 1'b0;
        mem_waddr       = idx_to_addr(idx_reg);
        mem_wdata       = mov_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_key_next  = '0;
                    res_data_next = '0;
                    if (req.req_type == REQ_INSERT)
                    begin
                        if (count_reg == IDX_W'(CAPACITY))
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            res_status_next = ST_OK;
                            count_next      = ins_idx;
                            idx_next        = ins_idx;
                            mov_next.key    = req.in_key;
                            mov_next.data   = req.in_data;
                            if (count_reg == '0)
                            begin
                                state_next = S_WFIN;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = idx_to_addr(ins_idx >> 1);
                                state_next = S_UP_CMP;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            res_status_next = ST_OK;
                            count_next      = count_reg - IDX_W'(1);
                            mem_re          = 1'b1;
                            mem_raddr       = '0;
                            state_next      = S_DN_ROOT;
                        end
                    end
                end
            end

            S_UP_CMP:
            begin
                // The parent of idx_reg is on the read port.
                if (mem_rdata.key > mov_reg.key)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                    idx_next  = parent_idx;
                    if (parent_idx > IDX_W'(1))
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_to_addr(parent_idx >> 1);
                    end
                    else
                    begin
                        state_next = S_WFIN;
                    end
                end
                else
                begin
                    state_next = S_WFIN;
                end
            end

            S_DN_ROOT:
            begin
                res_key_next  = mem_rdata.key;
                res_data_next = mem_rdata.data;
                // The last entry sits at position count + 1, address count.
                mem_re        = 1'b1;
                mem_raddr     = count_reg[ADDR_W-1:0];
                state_next    = S_DN_LAST;
            end

            S_DN_LAST:
            begin
                mov_next = mem_rdata;
                idx_next = IDX_W'(1);
                if (count_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else if (count_reg >= IDX_W'(2))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ADDR_W'(1);
                    state_next = S_DN_L;
                end
                else
                begin
                    state_next = S_WFIN;
                end
            end

            S_DN_L, S_DN_R:
            begin
                if (state_reg == S_DN_L && lc_wide < {1'b0, count_reg})
                begin
                    // A right child exists: fetch it before deciding.
                    left_next  = mem_rdata;
                    mem_re     = 1'b1;
                    mem_raddr  = lc_idx[ADDR_W-1:0];
                    state_next = S_DN_R;
                end
                else if (mov_reg.key > cand.key)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = cand;
                    idx_next  = cand_idx;
                    if (gc_ok)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = idx_to_addr(gc_wide[IDX_W-1:0]);
                        state_next = S_DN_L;
                    end
                    else
                    begin
                        state_next = S_WFIN;
                    end
                end
                else
                begin
                    state_next = S_WFIN;
                end
            end

            S_WFIN:
            begin
                mem_we     = 1'b1;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        mov_reg        <= mov_next;
        left_reg       <= left_next;
        res_key_reg    <= res_key_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
    end

    `BMHQ_ASSERT_ALWAYS(a_count_bound, count_reg <= IDX_W'(CAPACITY), "entry count above capacity")
    `BMHQ_ASSERT(a_no_rw_clash, (mem_re && mem_we) |-> (mem_raddr != mem_waddr), "read and write hit one entry")
    `BMHQ_ASSERT(a_sift_idx, (state_reg == S_UP_CMP || state_reg == S_DN_L || state_reg == S_DN_R) |-> (idx_reg != '0 && idx_reg <= count_reg), "sift position outside heap")
    `BMHQ_ASSERT(a_full_flag, (state_reg == S_EMIT && res_status_reg == ST_FULL) |-> (count_reg == IDX_W'(CAPACITY)), "full status on a heap with room")
    `BMHQ_ASSERT(a_quiet_write, mem_we |-> (state_reg != S_IDLE && state_reg != S_EMIT), "memory write outside a sift")

endmodule

### rtl/core/bmhq_out_stage.sv
module bmhq_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  bmhq_pkg::res_t res,
    input  logic           res_valid,
    output logic           res_ready,
    bmhq_rsp_if.source     rsp
);
    import bmhq_pkg::*;

    logic valid_reg, valid_next;
    res_t data_reg;

    assign res_ready     = !valid_reg || rsp.ready;
    assign rsp.valid     = valid_reg;
    assign rsp.out_key   = data_reg.key;
    assign rsp.out_data  = data_reg.data;
    assign rsp.status    = data_reg.status;
    assign rsp.occupancy = data_reg.occupancy;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid && res_ready)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            data_reg <= res;
        end
    end

endmodule

### rtl/core/binary_min_heap_queue_top.sv
// Channel  Direction  Item contents
// req      in         req_type, in_key, in_data
// rsp      out        out_key, out_data, status, occupancy
//
// One item is worked at a time; a result always follows its item.
// Insert: one parent key compared per step in S_UP_CMP, then a final write in S_WFIN.
// Remove: reads of the root and the last entry, then one or two reads per level examined
// (one memory read port) before the final write; removing the only entry skips both.
// Insert on a full heap or remove on an empty one goes straight to the result.
// Reset clears the state, the entry count and the output valid flag; the heap memory needs no clearing.
// The output register lets the next item start while a result waits on rsp.
module binary_min_heap_queue_top #(
    parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bmhq_req_if.sink   req,
    bmhq_rsp_if.source rsp
);
    import bmhq_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);

    res_t              res;
    logic              res_valid;
    logic              res_ready;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    entry_t            mem_rdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    entry_t            mem_wdata;

    bmhq_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .res      (res),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .mem_re   (mem_re),
        .mem_raddr(mem_raddr),
        .mem_rdata(mem_rdata),
        .mem_we   (mem_we),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata)
    );

    bmhq_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(CAPACITY)
    ) u_heap_ram (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    bmhq_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .rsp      (rsp)
    );

endmodule

### tb/binary_min_heap_queue_top_tb.sv
`timescale 1ns / 1ps

module binary_min_heap_queue_top_tb;
    import bmhq_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int DIR_ROWS = 25;
    localparam int TAIL_CYCLES = 64;
    localparam int MAX_REPORTS = 50;
    localparam int DRAIN_FLOOR = 448;

    typedef struct {
        logic              req_type;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
        bit                typed;
        res_t              want;
    } dir_step_t;

    logic clk;
    logic rst_n;

    bmhq_req_if req_ch ();
    bmhq_rsp_if rsp_ch ();

    binary_min_heap_queue_top #(
        .CAPACITY(CAP)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // Shadow copy of the heap, updated as each item is accepted.
    logic [KEY_W-1:0]  shadow_key  [1:CAP];
    logic [DATA_W-1:0] shadow_data [1:CAP];
    int unsigned       shadow_count;

    res_t pending_results [$];

    int  mismatches;
    int  results_seen;
    int  n_inserts;
    int  n_removes;
    int  n_full_hits;
    int  n_empty_hits;
    int  peak_count;
    int  random_sent;
    bit  req_idle_on;
    bit  rsp_idle_on;
    bit  quiet;

    dir_step_t plan [DIR_ROWS];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("simulation failed");
        $finish;
    end

    function automatic res_t mk_res(logic [KEY_W-1:0] k, logic [DATA_W-1:0] d,
                                    logic [STATUS_W-1:0] st, logic [OCC_W-1:0] occ);
        res_t r;
        r.key       = k;
        r.data      = d;
        r.status    = st;
        r.occupancy = occ;
        return r;
    endfunction

    function automatic dir_step_t dir_step(logic rt, logic [KEY_W-1:0] k,
                                           logic [DATA_W-1:0] d, bit typed, res_t want);
        dir_step_t s;
        s.req_type = rt;
        s.key      = k;
        s.data     = d;
        s.typed    = typed;
        s.want     = want;
        return s;
    endfunction

    // Applies one request to the shadow heap and returns the result it gives.
    function automatic res_t heap_apply(logic rt, logic [KEY_W-1:0] k, logic [DATA_W-1:0] d);
        res_t              r;
        int unsigned       i;
        int unsigned       c;
        int unsigned       n;
        logic [KEY_W-1:0]  mk;
        logic [DATA_W-1:0] md;
        r = '0;
        r.status = ST_OK;
        if (rt == REQ_INSERT)
        begin
            if (shadow_count >= CAP)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                shadow_count++;
                i = shadow_count;
                while (i > 1 && shadow_key[i / 2] > k)
                begin
                    shadow_key[i]  = shadow_key[i / 2];
                    shadow_data[i] = shadow_data[i / 2];
                    i = i / 2;
                end
                shadow_key[i]  = k;
                shadow_data[i] = d;
            end
        end
        else if (shadow_count == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            n      = shadow_count;
            mk     = shadow_key[n];
            md     = shadow_data[n];
            r.key  = shadow_key[1];
            r.data = shadow_data[1];
            n--;
            shadow_count = n;
            if (n != 0)
            begin
                i = 1;
                while (2 * i <= n)
                begin
                    c = 2 * i;
                    // Ties go to the left child.
                    if (c < n && shadow_key[c + 1] < shadow_key[c])
                        c++;
                    if (mk > shadow_key[c])
                    begin
                        shadow_key[i]  = shadow_key[c];
                        shadow_data[i] = shadow_data[c];
                        i = c;
                    end
                    else
                    begin
                        break;
                    end
                end
                shadow_key[i]  = mk;
                shadow_data[i] = md;
            end
        end
        r.occupancy = shadow_count[OCC_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    endtask

    task automatic check_result();
        res_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result with no item waiting: key %h data %h status %0d",
                                      rsp_ch.out_key, rsp_ch.out_data, rsp_ch.status));
        end
        else
        begin
            want = pending_results.pop_front();
            if (rsp_ch.out_key !== want.key)
                report_mismatch($sformatf("out_key got %h want %h", rsp_ch.out_key, want.key));
            if (rsp_ch.out_data !== want.data)
                report_mismatch($sformatf("out_data got %h want %h", rsp_ch.out_data, want.data));
            if (rsp_ch.status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d", rsp_ch.status, want.status));
            if (rsp_ch.occupancy !== want.occupancy)
                report_mismatch($sformatf("occupancy got %0d want %0d",
                                          rsp_ch.occupancy, want.occupancy));
        end
        results_seen++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            check_result();
    end

    // Result side: ready drops in bursts while idling is enabled.
    initial
    begin : rsp_side
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (rsp_idle_on && !quiet && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic push_request(logic rt, logic [KEY_W-1:0] k, logic [DATA_W-1:0] d,
                                bit typed, res_t want);
        res_t pred;
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= rt;
        req_ch.in_key   <= k;
        req_ch.in_data  <= d;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        pred = heap_apply(rt, k, d);
        if (rt == REQ_INSERT)
            n_inserts++;
        else
            n_removes++;
        if (pred.status == ST_FULL)
            n_full_hits++;
        if (pred.status == ST_EMPTY)
            n_empty_hits++;
        if (shadow_count > peak_count)
            peak_count = shadow_count;
        pending_results.push_back(typed ? want : pred);
    endtask

    task automatic rest(int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic maybe_rest();
        if (req_idle_on && !quiet && $urandom_range(0, 5) == 0)
            rest($urandom_range(1, 19));
    endtask

    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 3))
            0:       return KEY_W'($urandom_range(0, 15));
            1:       return $urandom_range(0, 1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
            default: return KEY_W'($urandom());
        endcase
    endfunction

    task automatic send_random(int insert_pct);
        logic rt;
        if (!quiet && random_sent % 50 == 0)
        begin
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
        end
        rt = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
        push_request(rt, pick_key(), DATA_W'($urandom()), 1'b0, '0);
        random_sent++;
        maybe_rest();
    endtask

    localparam logic [KEY_W-1:0] KMAX = {KEY_W{1'b1}};

    initial
    begin
        mismatches   = 0;
        results_seen = 0;
        n_inserts    = 0;
        n_removes    = 0;
        n_full_hits  = 0;
        n_empty_hits = 0;
        peak_count   = 0;
        random_sent  = 0;
        shadow_count = 0;
        req_idle_on  = 1'b1;
        rsp_idle_on  = 1'b1;
        quiet        = 1'b0;

        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_INSERT;
        req_ch.in_key   <= '0;
        req_ch.in_data  <= '0;

        plan = '{
            dir_step(REQ_REMOVE, '0, '0, 1, mk_res('0, '0, ST_EMPTY, 11'd0)),
            dir_step(REQ_INSERT, KMAX, 32'h7fffffff, 1, mk_res('0, '0, ST_OK, 11'd1)),
            dir_step(REQ_INSERT, '0, 32'h80000000, 1, mk_res('0, '0, ST_OK, 11'd2)),
            dir_step(REQ_REMOVE, KMAX, 32'hffffffff, 1,
                     mk_res('0, 32'h80000000, ST_OK, 11'd1)),
            // Removing the only entry leaves the heap empty.
            dir_step(REQ_REMOVE, '0, '0, 1, mk_res(KMAX, 32'h7fffffff, ST_OK, 11'd0)),
            dir_step(REQ_REMOVE, '0, '0, 1, mk_res('0, '0, ST_EMPTY, 11'd0)),
            // Equal keys with distinct data expose the tie rules.
            dir_step(REQ_INSERT, 31'd5, 32'hffffffff, 0, '0),
            dir_step(REQ_INSERT, 31'd5, 32'h00000000, 0, '0),
            dir_step(REQ_INSERT, 31'd5, 32'h00000001, 0, '0),
            dir_step(REQ_INSERT, 31'd3, 32'h55555555, 0, '0),
            dir_step(REQ_INSERT, 31'd5, 32'haaaaaaaa, 0, '0),
            dir_step(REQ_INSERT, 31'd9, 32'h12345678, 0, '0),
            dir_step(REQ_INSERT, 31'd2, 32'h00000000, 0, '0),
            dir_step(REQ_INSERT, 31'd5, 32'h00000007, 0, '0),
            dir_step(REQ_REMOVE, '0, '0, 0, '0),
            dir_step(REQ_REMOVE, '0, '0, 0, '0),
            dir_step(REQ_REMOVE, '0, '0, 0, '0),
            dir_step(REQ_REMOVE, '0, '0, 0, '0),
            dir_step(REQ_REMOVE, '0, '0, 0, '0),
            dir_step(REQ_REMOVE, '0, '0, 0, '0),
            dir_step(REQ_REMOVE, '0, '0, 0, '0),
            dir_step(REQ_REMOVE, '0, '0, 0, '0),
            dir_step(REQ_REMOVE, '0, '0, 1, mk_res('0, '0, ST_EMPTY, 11'd0)),
            dir_step(REQ_INSERT, KMAX, 32'h00000000, 0, '0),
            dir_step(REQ_INSERT, 31'd1, 32'hffffffff, 0, '0)
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            push_request(plan[i].req_type, plan[i].key, plan[i].data,
                         plan[i].typed, plan[i].want);
            maybe_rest();
        end
        hold_until_drained();

        // Mixed traffic around a small heap, hitting empty now and then.
        repeat (100) send_random(50);
        hold_until_drained();

        // Fill to capacity, then knock on the full heap a few times.
        while (shadow_count < CAP)
            send_random(98);
        repeat (4) send_random(100);
        send_random(0);
        repeat (2) send_random(100);
        hold_until_drained();

        // Drain a good part of the tree, with deep sifts from a full tree.
        while (shadow_count > DRAIN_FLOOR)
            send_random(2);
        repeat (3) send_random(0);

        // Last stretch runs back to back on both sides.
        quiet = 1'b1;
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        repeat (60) send_random(55);

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d inserts and %0d removes; %0d hit a full heap, %0d an empty one.",
                 n_inserts, n_removes, n_full_hits, n_empty_hits);
        $display("Peak occupancy %0d of %0d, %0d results checked, %0d mismatches.",
                 peak_count, CAP, results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
